// ===== rtl/core/pssg_pkg.sv =====
// ----------------------------------------------------------------------------
// pssg_pkg
// Shared constants and types for the pulse/saw sound generator: register
// decode values, field widths and the level scaling function.
// ----------------------------------------------------------------------------
`default_nettype none

package pssg_pkg;

  // Write address decode.
  localparam logic [15:0] ADDR_MASK  = 16'hF003;
  localparam logic [3:0]  PAGE_PLS_A = 4'h9;
  localparam logic [3:0]  PAGE_PLS_B = 4'hA;
  localparam logic [3:0]  PAGE_SAW   = 4'hB;
  localparam logic [1:0]  OFS_UNUSED = 2'd3;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_IDX_MUTE = 1'b0;

  // Field widths.
  localparam int MIX_W   = 14;
  localparam int PLS_W   = 12;
  localparam int SAW_W   = 13;
  localparam int PCNT_W  = 13;
  localparam int SCNT_W  = 14;
  localparam int ACC_W   = 9;
  localparam int MUTE_W  = 3;

  // Mute mask bit positions.
  localparam int MUTE_PLS_A = 0;
  localparam int MUTE_PLS_B = 1;
  localparam int MUTE_SAW   = 2;

  // Saw step on which the accumulator wraps back to zero.
  localparam logic [2:0] SAW_LAST_STEP = 3'd6;

  typedef logic [7:0] voice_reg_t;

  // Scale a 5-bit level by 192 (x128 + x64).
  function automatic logic [SAW_W-1:0] scale192(input logic [4:0] lvl);
    logic [SAW_W-1:0] ext;
    ext = {{(SAW_W-5){1'b0}}, lvl};
    return (ext << 7) + (ext << 6);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pulse_saw_sound_generator_unit.sv =====
// Latency: a tick item's result is valid in the cycle after the item is taken.
// Throughput: one item per cycle unless stalled; only stage: the output register.
// A register write item changes voice state and returns no result.
// Reset (synchronous, rst_n low) clears all voice registers, counters,
// the mute mask and the output valid flag.
// ----------------------------------------------------------------------------
// pulse_saw_sound_generator_unit
// Two pulse voices and one sawtooth voice. Each input transfer is either a
// voice register write or one clock tick that yields the three voice levels
// and their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_saw_sound_generator_unit
  import pssg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] addr, [23:16] data
  input  wire logic [0:0]  in_tuser,   // [0] func
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [13:0] mix_level, [25:14] pulse_a_level,
                                       // [37:26] pulse_b_level, [50:38] saw_level
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Voice registers and counters.
  voice_reg_t              pls_regs_r [6];
  voice_reg_t              pls_regs_nxt [6];
  voice_reg_t              saw_regs_r [3];
  voice_reg_t              saw_regs_nxt [3];
  logic [PCNT_W-1:0]       pls_cnt_r [2];
  logic [PCNT_W-1:0]       pls_cnt_nxt [2];
  logic [3:0]              pls_duty_r [2];
  logic [3:0]              pls_duty_nxt [2];
  logic [SCNT_W-1:0]       saw_cnt_r, saw_cnt_nxt;
  logic [ACC_W-1:0]        saw_acc_r, saw_acc_nxt;
  logic [2:0]              saw_step_r, saw_step_nxt;
  logic [MUTE_W-1:0]       mute_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [55:0]             out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic                    is_tick;
  logic                    is_write;
  logic [15:0]             addr;
  logic [7:0]              wdata;
  logic [15:0]             addr_m;
  logic [PLS_W-1:0]        pls_lvl [2];
  logic [SAW_W-1:0]        saw_lvl;
  logic [MIX_W-1:0]        mix_lvl;

  // Handshake: a new item is taken whenever the output slot is free or drains.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_tick   = in_xfer && (in_tuser[0] == FUNC_TICK);
  assign is_write  = in_xfer && (in_tuser[0] == FUNC_WRITE);
  assign addr      = in_tdata[15:0];
  assign wdata     = in_tdata[23:16];
  assign addr_m    = addr & ADDR_MASK;

  // Register writes from the input stream.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pls_regs_nxt[i] = pls_regs_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      saw_regs_nxt[i] = saw_regs_r[i];
    end
    if (is_write && (addr_m[1:0] != OFS_UNUSED)) begin
      case (addr_m[15:12])
        PAGE_PLS_A: pls_regs_nxt[{1'b0, addr_m[1:0]}] = wdata;
        PAGE_PLS_B: pls_regs_nxt[3'd3 + {1'b0, addr_m[1:0]}] = wdata;
        PAGE_SAW:   saw_regs_nxt[addr_m[1:0]] = wdata;
        default: ;
      endcase
    end
  end

  // Pulse voices: level from the current state, then counter advance.
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      logic [7:0]        r0, r1, r2;
      logic              run;
      logic [PLS_W-1:0]  amp;
      r0  = pls_regs_r[v*3];
      r1  = pls_regs_r[v*3+1];
      r2  = pls_regs_r[v*3+2];
      run = r2[7] && !mute_r[v];
      amp = PLS_W'(scale192({1'b0, r0[3:0]}));
      pls_cnt_nxt[v]  = pls_cnt_r[v];
      pls_duty_nxt[v] = pls_duty_r[v];
      if (!run) begin
        pls_lvl[v] = '0;
      end else if (r0[7]) begin
        pls_lvl[v] = amp;
      end else begin
        pls_lvl[v] = (pls_duty_r[v] > {1'b0, r0[6:4]}) ? amp : '0;
        if (is_tick) begin
          if (pls_cnt_r[v] <= PCNT_W'(1)) begin
            pls_cnt_nxt[v]  = {1'b0, r2[3:0], r1} + PCNT_W'(1);
            pls_duty_nxt[v] = pls_duty_r[v] + 4'd1;
          end else begin
            pls_cnt_nxt[v] = pls_cnt_r[v] - PCNT_W'(1);
          end
        end
      end
    end
  end

  // Saw voice: level from accumulator bits 7..3, then counter advance.
  always_comb begin
    logic [PCNT_W-1:0] per1;
    per1         = {1'b0, saw_regs_r[2][3:0], saw_regs_r[1]} + PCNT_W'(1);
    saw_cnt_nxt  = saw_cnt_r;
    saw_acc_nxt  = saw_acc_r;
    saw_step_nxt = saw_step_r;
    if (!saw_regs_r[2][7] || mute_r[MUTE_SAW]) begin
      saw_lvl = '0;
    end else begin
      saw_lvl = scale192(saw_acc_r[7:3]);
      if (is_tick) begin
        if (saw_cnt_r <= SCNT_W'(1)) begin
          saw_cnt_nxt = {per1, 1'b0};
          if (saw_step_r == SAW_LAST_STEP) begin
            saw_step_nxt = '0;
            saw_acc_nxt  = '0;
          end else begin
            saw_step_nxt = saw_step_r + 3'd1;
            saw_acc_nxt  = saw_acc_r + {3'b0, saw_regs_r[0][5:0]};
          end
        end else begin
          saw_cnt_nxt = saw_cnt_r - SCNT_W'(1);
        end
      end
    end
  end

  // Mix and output register next value.
  always_comb begin
    mix_lvl = {2'b0, pls_lvl[0]} + {2'b0, pls_lvl[1]} + {1'b0, saw_lvl};
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (is_tick) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'b0, saw_lvl, pls_lvl[1], pls_lvl[0], mix_lvl};
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        pls_regs_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        saw_regs_r[i] <= '0;
      end
      for (int v = 0; v < 2; v++) begin
        pls_cnt_r[v]  <= '0;
        pls_duty_r[v] <= '0;
      end
      saw_cnt_r   <= '0;
      saw_acc_r   <= '0;
      saw_step_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pls_regs_r  <= pls_regs_nxt;
      saw_regs_r  <= saw_regs_nxt;
      pls_cnt_r   <= pls_cnt_nxt;
      pls_duty_r  <= pls_duty_nxt;
      saw_cnt_r   <= saw_cnt_nxt;
      saw_acc_r   <= saw_acc_nxt;
      saw_step_r  <= saw_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration port: the mute mask at byte address 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == CFG_IDX_MUTE)) begin
      mute_r <= cfg_pwdata[MUTE_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_MUTE) ? {29'b0, mute_r} : 32'b0;

endmodule

`default_nettype wire

// ===== tb/sv/tb_pulse_saw_sound_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pulse_saw_sound_generator_unit
// Self-checking bench for the pulse/saw sound generator. A queue of register
// writes and clock ticks feeds a stream driver. A built-in voice model
// predicts the levels of every tick. A monitor compares each result transfer
// with the oldest prediction. Each random phase runs with a mute mask from a plan.
// ----------------------------------------------------------------------------
module tb_pulse_saw_sound_generator_unit
  import pssg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LEVEL_GAIN  = 192;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RX_HOLD     = 60;
  localparam int          RX_HOLD_AT  = 200;
  localparam logic [2:0]  MUTE_ADDR   = 3'(CFG_IDX_MUTE) << 2;
  // No register is mapped at this address; writes there must be ignored.
  localparam logic [2:0]  SPARE_ADDR  = 3'd4;

  typedef struct {
    logic        func;
    logic [15:0] addr;
    logic [7:0]  data;
  } sound_item_t;

  typedef struct {
    logic [MIX_W-1:0] mix_level;
    logic [PLS_W-1:0] pulse_a_level;
    logic [PLS_W-1:0] pulse_b_level;
    logic [SAW_W-1:0] saw_level;
  } voice_levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] addr, [23:16] data
  logic [0:0]  in_tuser = '0;   // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [13:0] mix_level, [25:14] pulse_a_level,
                                // [37:26] pulse_b_level, [50:38] saw_level
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pulse_saw_sound_generator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Voice model state.
  voice_reg_t        pls_reg [0:5];
  voice_reg_t        saw_reg [0:2];
  logic [PCNT_W-1:0] pls_count [0:1];
  logic [3:0]        pls_phase [0:1];
  logic [SCNT_W-1:0] saw_count;
  logic [ACC_W-1:0]  saw_acc;
  logic [2:0]        saw_steps;
  logic [MUTE_W-1:0] mute_bits;

  sound_item_t   pending_items[$];
  voice_levels_t levels_due[$];

  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;
  int   bad_count = 0;
  int   tx_wait = 0;
  bit   tx_burst = 1'b0;
  int   rx_wait = 0;
  bit   rx_burst = 1'b0;
  int   rx_stall_left = 0;
  int   results_seen = 0;
  int   cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance one pulse voice by a tick and return its level before the step.
  function automatic logic [PLS_W-1:0] step_pulse(input int v);
    voice_reg_t        r0, r1, r2;
    logic [PLS_W-1:0]  amp;
    logic [PLS_W-1:0]  lvl;
    r0 = pls_reg[3*v];
    r1 = pls_reg[3*v+1];
    r2 = pls_reg[3*v+2];
    amp = PLS_W'(int'(r0[3:0]) * LEVEL_GAIN);
    lvl = '0;
    if (r2[7] && !mute_bits[v]) begin
      if (r0[7]) begin
        // Constant mode holds the level and freezes the counters.
        lvl = amp;
      end else begin
        if (pls_phase[v] > {1'b0, r0[6:4]}) lvl = amp;
        if (pls_count[v] <= 1) begin
          pls_count[v] = {r2[3:0], r1} + PCNT_W'(1);
          pls_phase[v] = pls_phase[v] + 4'd1;
        end else begin
          pls_count[v] = pls_count[v] - PCNT_W'(1);
        end
      end
    end
    return lvl;
  endfunction

  // Advance the saw voice by a tick and return its level before the step.
  function automatic logic [SAW_W-1:0] step_saw();
    logic [SAW_W-1:0] lvl;
    lvl = '0;
    if (saw_reg[2][7] && !mute_bits[MUTE_SAW]) begin
      lvl = SAW_W'(int'(saw_acc[7:3]) * LEVEL_GAIN);
      if (saw_count <= 1) begin
        saw_count = ({2'b00, saw_reg[2][3:0], saw_reg[1]} + SCNT_W'(1)) << 1;
        saw_acc = saw_acc + ACC_W'(saw_reg[0][5:0]);
        saw_steps = saw_steps + 3'd1;
        // The seventh step wraps the ramp back to zero.
        if (saw_steps == 3'd7) begin
          saw_steps = '0;
          saw_acc = '0;
        end
      end else begin
        saw_count = saw_count - SCNT_W'(1);
      end
    end
    return lvl;
  endfunction

  function automatic voice_levels_t predict_levels();
    voice_levels_t lv;
    lv.pulse_a_level = step_pulse(MUTE_PLS_A);
    lv.pulse_b_level = step_pulse(MUTE_PLS_B);
    lv.saw_level = step_saw();
    lv.mix_level = MIX_W'(lv.pulse_a_level) + MIX_W'(lv.pulse_b_level) +
                   MIX_W'(lv.saw_level);
    return lv;
  endfunction

  // Register write decode: only offsets 0..2 of the three voice pages land.
  function automatic void apply_voice_write(input logic [15:0] addr,
                                            input logic [7:0] data);
    logic [15:0] m;
    m = addr & ADDR_MASK;
    if (m[1:0] != OFS_UNUSED) begin
      case (m[15:12])
        PAGE_PLS_A: pls_reg[m[1:0]] = data;
        PAGE_PLS_B: pls_reg[3 + m[1:0]] = data;
        PAGE_SAW:   saw_reg[m[1:0]] = data;
        default: ;
      endcase
    end
  endfunction

  function automatic void clear_voice_model();
    foreach (pls_reg[i]) pls_reg[i] = '0;
    foreach (saw_reg[i]) saw_reg[i] = '0;
    foreach (pls_count[i]) begin
      pls_count[i] = '0;
      pls_phase[i] = '0;
    end
    saw_count = '0;
    saw_acc = '0;
    saw_steps = '0;
    mute_bits = '0;
  endfunction

  // Transfer bookkeeping at the rising edge: check results, then predict.
  always @(posedge clk) begin
    voice_levels_t got;
    voice_levels_t want;
    in_xfer = rst_n && in_tvalid && in_tready;
    out_xfer = rst_n && out_tvalid && out_tready;
    if (out_xfer) begin
      got.mix_level = out_tdata[13:0];
      got.pulse_a_level = out_tdata[25:14];
      got.pulse_b_level = out_tdata[37:26];
      got.saw_level = out_tdata[50:38];
      if (levels_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result transfer: mix %0d a %0d b %0d saw %0d",
                   got.mix_level, got.pulse_a_level, got.pulse_b_level, got.saw_level);
      end else begin
        want = levels_due.pop_front();
        if (got.mix_level !== want.mix_level || got.pulse_a_level !== want.pulse_a_level ||
            got.pulse_b_level !== want.pulse_b_level || got.saw_level !== want.saw_level) begin
          bad_count++;
          if (bad_count <= 10)
            $display("level mismatch: expected mix %0d a %0d b %0d saw %0d,",
                     want.mix_level, want.pulse_a_level, want.pulse_b_level,
                     want.saw_level, " got mix %0d a %0d b %0d saw %0d",
                     got.mix_level, got.pulse_a_level,
                     got.pulse_b_level, got.saw_level);
        end
      end
    end
    if (in_xfer) begin
      if (in_tuser[0] == FUNC_TICK) levels_due.push_back(predict_levels());
      else apply_voice_write(in_tdata[15:0], in_tdata[23:16]);
    end
  end

  // Input driver: offers queued items with random gaps and burst stretches.
  always @(negedge clk) begin
    sound_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_xfer) begin
      // Hold the offered item until its transfer completes.
    end else if (tx_wait > 0) begin
      tx_wait--;
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= it.func;
      in_tdata <= {it.data, it.addr};
      if (($urandom & 31) == 0) tx_burst = !tx_burst;
      tx_wait = tx_burst ? 0 : $urandom_range(0, 5);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: random stalls per result, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_xfer) begin
        results_seen++;
        if (results_seen == RX_HOLD_AT) rx_stall_left = RX_HOLD;
        if (($urandom & 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pulse_saw_sound_generator_unit regression: fail");
    $finish;
  end

  task automatic push_tick();
    sound_item_t it;
    it.func = FUNC_TICK;
    it.addr = 16'($urandom);
    it.data = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_write(input logic [15:0] addr, input logic [7:0] data);
    sound_item_t it;
    it.func = FUNC_WRITE;
    it.addr = addr;
    it.data = data;
    pending_items.push_back(it);
  endtask

  // Mostly ticks and well-formed voice writes with short periods, some noise.
  task automatic push_random_items(input int count);
    int          pick;
    int          sel;
    logic [3:0]  page;
    logic [1:0]  ofs;
    logic [7:0]  data;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_tick();
      end else if (pick < 90) begin
        sel = $urandom_range(0, 8);
        page = (sel < 3) ? PAGE_PLS_A : (sel < 6) ? PAGE_PLS_B : PAGE_SAW;
        ofs = 2'(sel % 3);
        data = 8'($urandom);
        if (ofs == 2'd2 && $urandom_range(0, 3) != 0)
          data = {1'b1, 3'($urandom), 4'b0000};
        else if (ofs == 2'd1 && $urandom_range(0, 3) != 0)
          data = 8'($urandom_range(0, 7));
        push_write({page, 10'($urandom), ofs}, data);
      end else begin
        push_write(16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Waits until every item has been transferred and every result checked.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || levels_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write on the configuration port.
  task automatic write_cfg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == MUTE_ADDR) mute_bits = value[MUTE_W-1:0];
  endtask

  // Stimulus sequencing.
  initial begin
    logic [31:0] mute_plan [0:8];
    mute_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                  32'h0000_0004, 32'hA5A5_A5A3, 32'h0000_0005, 32'hFFFF_FFF6,
                  32'h0000_0000};
    clear_voice_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: silence at reset, constant mode, fast duty and saw stepping,
    // ignored addresses, and longer periods written through aliased addresses.
    push_tick();
    push_write(16'h9000, 8'h8F);
    push_write(16'h9002, 8'h80);
    push_tick();
    push_write(16'hA000, 8'h3A);
    push_write(16'hA001, 8'h00);
    push_write(16'hA002, 8'h80);
    push_write(16'hB000, 8'h3F);
    push_write(16'hB001, 8'h00);
    push_write(16'hB002, 8'h80);
    push_write(16'h9003, 8'hFF);
    push_write(16'hFFFF, 8'hFF);
    push_write(16'h0000, 8'hFF);
    repeat (6) push_tick();
    push_write(16'hBFFD, 8'hFF);
    push_write(16'hAFFE, 8'h8F);
    repeat (2) push_tick();
    wait_drained();

    // Random phases, each under its own mute mask.
    foreach (mute_plan[p]) begin
      write_cfg(MUTE_ADDR, mute_plan[p]);
      if (p == 3) write_cfg(SPARE_ADDR, $urandom);
      push_random_items(90);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (bad_count == 0)
      $display("pulse_saw_sound_generator_unit regression: pass");
    else
      $display("pulse_saw_sound_generator_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pssg_pkg.sv
rtl/core/pulse_saw_sound_generator_unit.sv
tb/sv/tb_pulse_saw_sound_generator_unit.sv
